### rtl/rpyd_pkg.sv
package rpyd_pkg;

  localparam int COORD_BITS   = 24;
  localparam int MAG_W        = COORD_BITS + 1;
  localparam int POS_W        = $clog2(MAG_W);
  localparam int NORM_POS     = 28;
  localparam int NW           = NORM_POS + 1;
  localparam int SH_W         = 6;
  localparam int A_W          = NW + 1;
  localparam int SQ_STEPS     = A_W;
  localparam int RAD_W        = 2 * SQ_STEPS;
  localparam int REM_W        = SQ_STEPS + 2;
  localparam int X_W          = A_W + 3;
  localparam int Z_W          = 24;
  localparam int ANG_W        = Z_W;
  localparam int ANG_FRAC     = 16;
  localparam int DEG_W        = ANG_W - ANG_FRAC + 1;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam logic [ANG_W-1:0] DEG45  = ANG_W'(45 * 65536);
  localparam logic [ANG_W-1:0] DEG90  = ANG_W'(90 * 65536);
  localparam logic [ANG_W-1:0] DEG180 = ANG_W'(180 * 65536);

  typedef struct packed {
    logic          ok;
    logic          nx;
    logic          ny;
    logic          nz;
    logic [NW-1:0] mx;
    logic [NW-1:0] my;
    logic [NW-1:0] mz;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [SQ_STEPS-1:0] root;
    logic [RAD_W-1:0]    rad;
    side_t               side;
  } sq_t;

  typedef struct packed {
    logic zero;
    logic bz;
    logic eq;
    logic swap;
    logic xneg;
    logic yneg;
    logic tag;
  } ctx_t;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
    ctx_t                  ctx;
  } cs_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [STEP_W-1:0] step);
    logic signed [Z_W-1:0] v;
    case (step)
      5'd0:    v = Z_W'(2949120);
      5'd1:    v = Z_W'(1740967);
      5'd2:    v = Z_W'(919879);
      5'd3:    v = Z_W'(466945);
      5'd4:    v = Z_W'(234379);
      5'd5:    v = Z_W'(117304);
      5'd6:    v = Z_W'(58666);
      5'd7:    v = Z_W'(29335);
      5'd8:    v = Z_W'(14668);
      5'd9:    v = Z_W'(7334);
      5'd10:   v = Z_W'(3667);
      5'd11:   v = Z_W'(1833);
      5'd12:   v = Z_W'(917);
      5'd13:   v = Z_W'(458);
      5'd14:   v = Z_W'(229);
      5'd15:   v = Z_W'(115);
      5'd16:   v = Z_W'(57);
      5'd17:   v = Z_W'(29);
      5'd18:   v = Z_W'(14);
      5'd19:   v = Z_W'(7);
      5'd20:   v = Z_W'(4);
      5'd21:   v = Z_W'(2);
      5'd22:   v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/rpyd_sqrt_cell.sv
module rpyd_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rpyd_pkg::sq_t d_i,
  output logic          valid_o,
  output rpyd_pkg::sq_t q_o
);
  import rpyd_pkg::*;

  logic [REM_W-1:0] trial;
  logic [REM_W:0]   diff;
  sq_t              cell_d;
  sq_t              cell_q;
  logic             valid_q;

  always_comb begin
    trial       = {d_i.rem[REM_W-3:0], d_i.rad[RAD_W-1 -: 2]};
    diff        = {1'b0, trial} - {1'b0, d_i.root, 2'b01};
    cell_d      = d_i;
    cell_d.rad  = d_i.rad << 2;
    if (!diff[REM_W]) begin
      cell_d.rem  = diff[REM_W-1:0];
      cell_d.root = {d_i.root[SQ_STEPS-2:0], 1'b1};
    end else begin
      cell_d.rem  = trial;
      cell_d.root = {d_i.root[SQ_STEPS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign q_o     = cell_q;

endmodule

### rtl/rpyd_sqrt.sv
module rpyd_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rpyd_pkg::RAD_W-1:0]  rad_i,
  input  rpyd_pkg::side_t             side_i,
  output logic                        valid_o,
  output logic [rpyd_pkg::SQ_STEPS-1:0] root_o,
  output rpyd_pkg::side_t             side_o
);
  import rpyd_pkg::*;

  sq_t  stage [SQ_STEPS+1];
  logic vld   [SQ_STEPS+1];

  assign stage[0] = {REM_W'(0), SQ_STEPS'(0), rad_i, side_i};
  assign vld[0]   = valid_i;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_cell
    rpyd_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (vld[i]),
      .d_i     (stage[i]),
      .valid_o (vld[i+1]),
      .q_o     (stage[i+1])
    );
  end

  assign valid_o = vld[SQ_STEPS];
  assign root_o  = stage[SQ_STEPS].root;
  assign side_o  = stage[SQ_STEPS].side;

endmodule

### rtl/rpyd_cordic_cell.sv
module rpyd_cordic_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [rpyd_pkg::STEP_W-1:0] step_i,
  input  logic                        valid_i,
  input  rpyd_pkg::cs_t               d_i,
  output logic                        valid_o,
  output rpyd_pkg::cs_t               q_o
);
  import rpyd_pkg::*;

  logic signed [X_W-1:0] xv;
  logic signed [X_W-1:0] yv;
  logic signed [X_W-1:0] xs;
  logic signed [X_W-1:0] ys;
  logic signed [Z_W-1:0] at;
  cs_t                   cell_d;
  cs_t                   cell_q;
  logic                  valid_q;

  always_comb begin
    xv     = d_i.x;
    yv     = d_i.y;
    xs     = xv >>> step_i;
    ys     = yv >>> step_i;
    at     = atan_lut(step_i);
    cell_d = d_i;
    if (!yv[X_W-1]) begin
      cell_d.x = xv + ys;
      cell_d.y = yv - xs;
      cell_d.z = d_i.z + at;
    end else begin
      cell_d.x = xv - ys;
      cell_d.y = yv + xs;
      cell_d.z = d_i.z - at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign q_o     = cell_q;

endmodule

### rtl/rpyd_cordic.sv
module rpyd_cordic (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic                            tag_i,
  input  logic [rpyd_pkg::A_W-1:0]        ym_i,
  input  logic                            yneg_i,
  input  logic [rpyd_pkg::A_W-1:0]        xm_i,
  input  logic                            xneg_i,
  output logic                            valid_o,
  output logic                            tag_o,
  output logic signed [rpyd_pkg::DEG_W-1:0] deg_o
);
  import rpyd_pkg::*;

  logic [A_W-1:0]   a;
  logic [A_W-1:0]   b;
  cs_t              pre_d;
  cs_t              pre_q;
  logic             pre_v_q;
  cs_t              chain [CORDIC_STEPS+1];
  logic             vld   [CORDIC_STEPS+1];
  cs_t              last;
  logic [ANG_W-1:0] oct;
  logic [ANG_W-1:0] a1_d;
  logic [ANG_W-1:0] a1_q;
  ctx_t             p1_ctx_q;
  logic             p1_v_q;
  logic [ANG_W-1:0] a2;
  logic [DEG_W-1:0] whole;
  logic [DEG_W-1:0] deg_d;
  logic [DEG_W-1:0] deg_q;
  logic             tag_q;
  logic             p2_v_q;

  always_comb begin
    pre_d.ctx.swap = ym_i > xm_i;
    a              = pre_d.ctx.swap ? ym_i : xm_i;
    b              = pre_d.ctx.swap ? xm_i : ym_i;
    pre_d.ctx.zero = a == '0;
    pre_d.ctx.bz   = b == '0;
    pre_d.ctx.eq   = a == b;
    pre_d.ctx.xneg = xneg_i;
    pre_d.ctx.yneg = yneg_i;
    pre_d.ctx.tag  = tag_i;
    pre_d.x        = {{(X_W-A_W){1'b0}}, a};
    pre_d.y        = {{(X_W-A_W){1'b0}}, b};
    pre_d.z        = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= 1'b0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
    end else if (en_i) begin
      pre_v_q <= valid_i;
      p1_v_q  <= vld[CORDIC_STEPS];
      p2_v_q  <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q    <= pre_d;
      a1_q     <= a1_d;
      p1_ctx_q <= last.ctx;
      deg_q    <= deg_d;
      tag_q    <= p1_ctx_q.tag;
    end
  end

  assign chain[0] = pre_q;
  assign vld[0]   = pre_v_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    rpyd_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .step_i  (STEP_W'(i)),
      .valid_i (vld[i]),
      .d_i     (chain[i]),
      .valid_o (vld[i+1]),
      .q_o     (chain[i+1])
    );
  end

  assign last = chain[CORDIC_STEPS];

  // clamp, then fold the octant back to the quadrant
  always_comb begin
    if (last.z[Z_W-1]) begin
      oct = '0;
    end else if (ANG_W'(last.z) > DEG45) begin
      oct = DEG45;
    end else begin
      oct = ANG_W'(last.z);
    end
    if (last.ctx.bz) begin
      oct = '0;
    end else if (last.ctx.eq) begin
      oct = DEG45;
    end
    if (last.ctx.zero) begin
      a1_d = '0;
    end else if (last.ctx.swap) begin
      a1_d = DEG90 - oct;
    end else begin
      a1_d = oct;
    end
  end

  always_comb begin
    a2    = p1_ctx_q.xneg ? DEG180 - a1_q : a1_q;
    whole = {1'b0, a2[ANG_W-1:ANG_FRAC]};
    deg_d = (p1_ctx_q.xneg ^ p1_ctx_q.yneg) ? DEG_W'(-whole) : whole;
  end

  assign valid_o = p2_v_q;
  assign tag_o   = tag_q;
  assign deg_o   = deg_q;

endmodule

### rtl/relative_yaw_pitch_degrees.sv
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// in       | in_valid_i / in_stall_o    | camera_{x,y,z}_i, target_{x,y,z}_i, lookup_ok_i
// out      | out_valid_o / out_stall_i  | yaw_deg_o, tilt_deg_o, succeeded_o
//
// Takes one item per cycle while in_stall_o is low; each result passes through the
// 30-cell square-root chain and the 24-cell CORDIC chains.
// Reset clears every stage valid bit and the output valid bit; no warm-up pass.
// The whole chain holds only when the output register is full and stalled and the
// last stage has an item; otherwise it advances and bubbles close up.
module relative_yaw_pitch_degrees (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [rpyd_pkg::COORD_BITS-1:0] camera_x_i,
  input  logic signed [rpyd_pkg::COORD_BITS-1:0] camera_y_i,
  input  logic signed [rpyd_pkg::COORD_BITS-1:0] camera_z_i,
  input  logic signed [rpyd_pkg::COORD_BITS-1:0] target_x_i,
  input  logic signed [rpyd_pkg::COORD_BITS-1:0] target_y_i,
  input  logic signed [rpyd_pkg::COORD_BITS-1:0] target_z_i,
  input  logic                                 lookup_ok_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [rpyd_pkg::DEG_W-1:0]    yaw_deg_o,
  output logic signed [rpyd_pkg::DEG_W-1:0]    tilt_deg_o,
  output logic                                 succeeded_o
);
  import rpyd_pkg::*;

  localparam int WIDE = MAG_W + NW;

  logic [COORD_BITS-1:0] cam [3];
  logic [COORD_BITS-1:0] tgt [3];
  logic                  adv;
  logic                  last_v;
  logic                  out_load;

  // difference stage
  logic [MAG_W-1:0] diff [3];
  logic [MAG_W-1:0] mag1_d [3];
  logic [MAG_W-1:0] mag1_q [3];
  logic [2:0]       neg1_d;
  logic [2:0]       neg1_q;
  logic             ok1_q;
  logic             s1_v_q;

  // leading-one stage
  logic [MAG_W-1:0] orv;
  logic [POS_W-1:0] pos2_d;
  logic [POS_W-1:0] pos2_q;
  logic [MAG_W-1:0] mag2_q [3];
  logic [2:0]       neg2_q;
  logic             ok2_q;
  logic             s2_v_q;

  // normalize stage
  logic [SH_W-1:0]  sh;
  logic [WIDE-1:0]  wide [3];
  logic [NW-1:0]    norm [3];
  side_t            side3_d;
  side_t            side3_q;
  logic             s3_v_q;

  // square and sum stages
  logic [2*NW-1:0]  sqx_q;
  logic [2*NW-1:0]  sqy_q;
  side_t            side4_q;
  logic             s4_v_q;
  logic [RAD_W-1:0] rad5_q;
  side_t            side5_q;
  logic             s5_v_q;

  logic                sq_v;
  logic [SQ_STEPS-1:0] root;
  side_t               side6;
  logic                yaw_v;
  logic                pitch_v;
  logic                yaw_ok;
  logic                ok_last;
  logic [DEG_W-1:0]    yaw_last;
  logic [DEG_W-1:0]    pitch_last;

  logic             out_v_q;
  logic [DEG_W-1:0] yaw_q;
  logic [DEG_W-1:0] pitch_q;
  logic             succ_q;

  assign cam[0] = camera_x_i;
  assign cam[1] = camera_y_i;
  assign cam[2] = camera_z_i;
  assign tgt[0] = target_x_i;
  assign tgt[1] = target_y_i;
  assign tgt[2] = target_z_i;

  assign out_load   = !out_v_q || !out_stall_i;
  assign adv        = !(out_v_q && out_stall_i && last_v);
  assign in_stall_o = !adv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]   = {tgt[i][COORD_BITS-1], tgt[i]} - {cam[i][COORD_BITS-1], cam[i]};
      neg1_d[i] = diff[i][MAG_W-1];
      mag1_d[i] = neg1_d[i] ? MAG_W'(-diff[i]) : diff[i];
    end
  end

  always_comb begin
    orv    = mag1_q[0] | mag1_q[1] | mag1_q[2];
    pos2_d = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (orv[i]) begin
        pos2_d = POS_W'(i);
      end
    end
  end

  always_comb begin
    if (int'(pos2_q) <= NORM_POS) begin
      sh = SH_W'(NORM_POS) - SH_W'(pos2_q);
    end else begin
      sh = SH_W'(pos2_q) - SH_W'(NORM_POS);
    end
    for (int i = 0; i < 3; i++) begin
      if (int'(pos2_q) <= NORM_POS) begin
        wide[i] = {{NW{1'b0}}, mag2_q[i]} << sh;
      end else begin
        wide[i] = {{NW{1'b0}}, mag2_q[i]} >> sh;
      end
      norm[i] = wide[i][NW-1:0];
    end
    side3_d.ok = ok2_q;
    side3_d.mx = norm[0];
    side3_d.my = norm[1];
    side3_d.mz = norm[2];
    side3_d.nx = neg2_q[0] && (norm[0] != '0);
    side3_d.ny = neg2_q[1] && (norm[1] != '0);
    side3_d.nz = neg2_q[2] && (norm[2] != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag1_q  <= mag1_d;
      neg1_q  <= neg1_d;
      ok1_q   <= lookup_ok_i;
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      ok2_q   <= ok1_q;
      pos2_q  <= pos2_d;
      side3_q <= side3_d;
      sqx_q   <= side3_q.mx * side3_q.mx;
      sqy_q   <= side3_q.my * side3_q.my;
      side4_q <= side3_q;
      rad5_q  <= RAD_W'(sqx_q) + RAD_W'(sqy_q);
      side5_q <= side4_q;
    end
  end

  rpyd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s5_v_q),
    .rad_i   (rad5_q),
    .side_i  (side5_q),
    .valid_o (sq_v),
    .root_o  (root),
    .side_o  (side6)
  );

  rpyd_cordic u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_v),
    .tag_i   (side6.ok),
    .ym_i    ({1'b0, side6.my}),
    .yneg_i  (side6.ny),
    .xm_i    ({1'b0, side6.mx}),
    .xneg_i  (side6.nx),
    .valid_o (yaw_v),
    .tag_o   (yaw_ok),
    .deg_o   (yaw_last)
  );

  rpyd_cordic u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_v),
    .tag_i   (side6.ok),
    .ym_i    (root),
    .yneg_i  (1'b0),
    .xm_i    ({1'b0, side6.mz}),
    .xneg_i  (side6.nz),
    .valid_o (pitch_v),
    .tag_o   (ok_last),
    .deg_o   (pitch_last)
  );

  assign last_v = yaw_v && pitch_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= last_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && last_v) begin
      yaw_q   <= yaw_ok ? yaw_last : '0;
      pitch_q <= ok_last ? pitch_last : '0;
      succ_q  <= ok_last;
    end
  end

  assign out_valid_o = out_v_q;
  assign yaw_deg_o   = yaw_q;
  assign tilt_deg_o  = pitch_q;
  assign succeeded_o = succ_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !succeeded_o |-> yaw_deg_o == '0 && tilt_deg_o == '0)
    else $error("failed lookup gave nonzero angles");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> yaw_deg_o >= -180 && yaw_deg_o <= 180)
    else $error("yaw out of range");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tilt_deg_o >= -180 && tilt_deg_o <= 180)
    else $error("pitch out of range");

  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_v && out_valid_o && out_stall_i |-> in_stall_o)
    else $error("chain advanced while output full");

endmodule
